FILE: hw/rtl/mvad_pkg.sv
// Shared types, constants and helper functions for the milli-value panel formatter.
package mvad_pkg;

  localparam int unsigned DIGITS_TOTAL  = 8;
  localparam int unsigned MODULE_DIGITS = DIGITS_TOTAL / 2;
  localparam int unsigned POS_W         = $clog2(DIGITS_TOTAL);
  localparam int unsigned DIGIT_W       = $clog2(MODULE_DIGITS);

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned WHOLE_W = 7;
  localparam int unsigned FRAC_W  = 10;
  localparam int unsigned BCD_W   = 4;

  // this product >> RECIP_SHIFT is floor(v / 1000) or one above it for any 16-bit v
  localparam int unsigned RECIP_1000  = 1049;
  localparam int unsigned RECIP_SHIFT = 20;

  // characters 5 and 6 are wired crosswise on the second module
  localparam int unsigned SWAP_POS_A = 5;
  localparam int unsigned SWAP_POS_B = 6;

  typedef enum logic [1:0] {
    CMD_SHOW_VOLT  = 2'd0,
    CMD_SHOW_CURR  = 2'd1,
    CMD_BLANK_VOLT = 2'd2,
    CMD_BLANK_CURR = 2'd3
  } cmd_e;

  typedef logic [6:0] char_t;

  localparam char_t CH_NUL   = 7'h00;
  localparam char_t CH_SPACE = 7'h20;
  localparam char_t CH_DOT   = 7'h2E;
  localparam char_t CH_ZERO  = 7'h30;
  localparam char_t CH_A     = 7'h41;
  localparam char_t CH_V     = 7'h56;

  function automatic char_t swap_bits56(char_t c);
    return {c[5], c[6], c[4:0]};
  endfunction

  function automatic char_t digit_char(logic [BCD_W-1:0] d);
    return CH_ZERO + {3'b000, d};
  endfunction

endpackage

FILE: hw/rtl/mvad_req_if.sv
// Request channel: command and milli-unit value.
interface mvad_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] value_milli;

  modport source (output valid, output cmd, output value_milli, input ready);
  modport sink   (input valid, input cmd, input value_milli, output ready);
endinterface

FILE: hw/rtl/mvad_res_if.sv
// Result channel: one character write to a display module.
interface mvad_res_if;
  logic       valid;
  logic       ready;
  logic       panel;
  logic       module_res;
  logic [1:0] digit;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output panel, output module_res, output digit,
                  output char_code, output last, input ready);
  modport sink   (input valid, input panel, input module_res, input digit,
                  input char_code, input last, output ready);
endinterface

FILE: hw/rtl/milli_value_to_alnum_digits.sv
// Top level: milli-unit value to eight character writes for two 4-digit modules.
//
// Usage:
//   req_i carries a command (show voltage, show current, blank either panel)
//   and a 16-bit value in milli-units. Each request yields eight writes on
//   res_o, one per cycle while res_o.ready is high: module 0 digits 0..3,
//   then module 1 digits 0..3, the eighth flagged by last.
//   Pipeline: an accepted request passes four register stages (operand,
//   reciprocal product, whole and fraction, decimal digits) and is then
//   loaded into the character buffer, which shifts it out.
//   Throughput: the buffer sends one character per cycle while res_o.ready
//   is high, and loads a new run only after the last write. Up to four
//   further requests are taken into the stages while a run is still being sent.
//   Stall: with res_o.ready low the current write holds; req_i.ready drops
//   while the digit stage holds a request that the buffer cannot load yet,
//   and every stage behind it holds as well.
//   Reset: all stages and the output buffer are emptied; no write is pending.
module milli_value_to_alnum_digits
  import mvad_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mvad_req_if.sink   req_i,
  mvad_res_if.source res_o
);

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGITS_TOTAL - 1);

  logic adv;
  logic load;
  logic beat;

  // stage 1: operands
  logic                s1_vld_q;
  cmd_e                s1_cmd_q;
  logic [VALUE_W-1:0]  s1_val_q;
  // stage 2: estimated quotient
  logic                s2_vld_q;
  cmd_e                s2_cmd_q;
  logic [VALUE_W-1:0]  s2_val_q;
  logic [WHOLE_W-1:0]  s2_quo_q;
  logic [WHOLE_W-1:0]  s2_quo_d;
  logic [VALUE_W+10:0] quo_prod;
  // stage 3: whole and fraction
  logic                s3_vld_q;
  cmd_e                s3_cmd_q;
  logic [WHOLE_W-1:0]  s3_whole_q;
  logic [FRAC_W-1:0]   s3_frac_q;
  logic [WHOLE_W-1:0]  s3_whole_d;
  logic [FRAC_W-1:0]   s3_frac_d;
  logic [VALUE_W:0]    quo_k;
  logic [VALUE_W:0]    rem_raw;
  logic [VALUE_W:0]    rem_fix;
  logic                quo_over;
  // stage 4: decimal digits
  logic                s4_vld_q;
  cmd_e                s4_cmd_q;
  logic [BCD_W-1:0]    s4_wten_q;
  logic [BCD_W-1:0]    s4_wone_q;
  logic                s4_ge10_q;
  logic [WHOLE_W-1:0]  s4_cv_q;
  logic [BCD_W-1:0]    s4_fone_q;
  logic [10:0]         wt_prod;
  logic [WHOLE_W-1:0]  w_rem;
  logic [17:0]         cv_prod;
  logic [WHOLE_W-1:0]  cv_d;
  logic [FRAC_W-1:0]   f_rem;
  // text
  logic [14:0]         h_prod;
  logic [BCD_W-1:0]    fhun;
  logic [WHOLE_W-1:0]  t_rem;
  logic [BCD_W-1:0]    ften;
  char_t               unit_ch;
  char_t               txt      [DIGITS_TOTAL];
  char_t               chars_d  [DIGITS_TOTAL];
  // output buffer
  logic                out_vld_q;
  logic                out_pnl_q;
  logic [POS_W-1:0]    pos_q;
  char_t               chars_q  [DIGITS_TOTAL];

  assign beat = out_vld_q && res_o.ready;
  assign load = !out_vld_q || (beat && (pos_q == POS_LAST));
  assign adv  = !s4_vld_q || load;

  assign req_i.ready = adv;

  assign quo_prod = (VALUE_W+11)'(s1_val_q) * (VALUE_W+11)'(RECIP_1000);
  assign s2_quo_d = quo_prod[RECIP_SHIFT +: WHOLE_W];

  assign quo_k    = (VALUE_W+1)'(s2_quo_q) * (VALUE_W+1)'(1000);
  assign rem_raw  = {1'b0, s2_val_q} - quo_k;
  assign quo_over = quo_k > {1'b0, s2_val_q};
  assign rem_fix  = rem_raw + (VALUE_W+1)'(1000);
  assign s3_whole_d = quo_over ? s2_quo_q - WHOLE_W'(1) : s2_quo_q;
  assign s3_frac_d  = quo_over ? rem_fix[FRAC_W-1:0] : rem_raw[FRAC_W-1:0];

  assign wt_prod = 11'(s3_whole_q) * 11'd13;
  assign w_rem   = s3_whole_q - WHOLE_W'(wt_prod[10:7]) * WHOLE_W'(10);
  assign cv_prod = 18'(s3_frac_q) * 18'd205;
  assign cv_d    = cv_prod[17:11];
  assign f_rem   = s3_frac_q - FRAC_W'(cv_d) * FRAC_W'(10);

  assign h_prod  = 15'(s4_cv_q) * 15'd205;
  assign fhun    = h_prod[14:11];
  assign t_rem   = s4_cv_q - WHOLE_W'(fhun) * WHOLE_W'(10);
  assign ften    = t_rem[BCD_W-1:0];
  assign unit_ch = (s4_cmd_q == CMD_SHOW_VOLT) ? CH_V : CH_A;

  always_comb begin
    for (int i = 0; i < DIGITS_TOTAL; i++) begin
      txt[i] = CH_SPACE;
    end
    unique case (s4_cmd_q) inside
      CMD_SHOW_VOLT, CMD_SHOW_CURR: begin
        if (s4_ge10_q) begin
          txt[0] = digit_char(s4_wten_q);
          txt[1] = digit_char(s4_wone_q);
          txt[2] = CH_DOT;
          txt[3] = digit_char(fhun);
          txt[4] = digit_char(ften);
          if (s4_cmd_q == CMD_SHOW_VOLT) begin
            txt[5] = CH_SPACE;
            txt[6] = CH_V;
          end else begin
            txt[5] = digit_char(s4_fone_q);
            txt[6] = CH_SPACE;
          end
        end else begin
          txt[0] = digit_char(s4_wone_q);
          txt[1] = CH_DOT;
          txt[2] = digit_char(fhun);
          txt[3] = digit_char(ften);
          txt[4] = digit_char(s4_fone_q);
          txt[5] = CH_SPACE;
          txt[6] = unit_ch;
        end
        txt[7] = CH_NUL;
      end
      CMD_BLANK_VOLT, CMD_BLANK_CURR: begin
        for (int i = 0; i < DIGITS_TOTAL; i++) begin
          txt[i] = CH_SPACE;
        end
      end
      default: begin
        for (int i = 0; i < DIGITS_TOTAL; i++) begin
          txt[i] = CH_SPACE;
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DIGITS_TOTAL; i++) begin
      if (i == SWAP_POS_A) begin
        chars_d[i] = swap_bits56(txt[SWAP_POS_B]);
      end else if (i == SWAP_POS_B) begin
        chars_d[i] = swap_bits56(txt[SWAP_POS_A]);
      end else begin
        chars_d[i] = swap_bits56(txt[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= req_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q   <= cmd_e'(req_i.cmd);
      s1_val_q   <= req_i.value_milli;
      s2_cmd_q   <= s1_cmd_q;
      s2_val_q   <= s1_val_q;
      s2_quo_q   <= s2_quo_d;
      s3_cmd_q   <= s2_cmd_q;
      s3_whole_q <= s3_whole_d;
      s3_frac_q  <= s3_frac_d;
      s4_cmd_q   <= s3_cmd_q;
      s4_wten_q  <= wt_prod[10:7];
      s4_wone_q  <= w_rem[BCD_W-1:0];
      s4_ge10_q  <= s3_whole_q >= WHOLE_W'(10);
      s4_cv_q    <= cv_d;
      s4_fone_q  <= f_rem[BCD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pos_q     <= '0;
    end else if (load) begin
      out_vld_q <= s4_vld_q;
      pos_q     <= '0;
    end else if (beat) begin
      pos_q     <= pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pnl_q <= s4_cmd_q[0];
      chars_q   <= chars_d;
    end else if (beat) begin
      for (int i = 0; i < DIGITS_TOTAL - 1; i++) begin
        chars_q[i] <= chars_q[i+1];
      end
      chars_q[DIGITS_TOTAL-1] <= CH_SPACE;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.panel      = out_pnl_q;
  assign res_o.module_res = pos_q[POS_W-1];
  assign res_o.digit      = pos_q[DIGIT_W-1:0];
  assign res_o.char_code  = chars_q[0];
  assign res_o.last       = pos_q == POS_LAST;

endmodule

FILE: hw/rtl/mvad_chk.sv
// Port-level checks on the write sequence of the panel formatter, bound to the top level.
module mvad_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       res_panel_i,
  input logic       res_module_i,
  input logic [1:0] res_digit_i,
  input logic       res_last_i
);

  logic beat;
  assign beat = res_valid_i && res_ready_i;

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !res_last_i) |=> res_valid_i)
    else $error("write run broke off before its last write");

  a_pos_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !res_last_i) |=> ({res_module_i, res_digit_i} ==
                               $past({res_module_i, res_digit_i}) + 3'd1))
    else $error("module/digit position did not step by one");

  a_panel_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !res_last_i) |=> $stable(res_panel_i))
    else $error("panel changed within a run");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_last_i == (res_module_i && (res_digit_i == 2'd3))))
    else $error("last flag not on module 1 digit 3");

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && res_last_i) |=> (!res_valid_i || ({res_module_i, res_digit_i} == 3'd0)))
    else $error("new run did not start at module 0 digit 0");

endmodule

bind milli_value_to_alnum_digits mvad_chk u_mvad_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_panel_i  (res_o.panel),
  .res_module_i (res_o.module_res),
  .res_digit_i  (res_o.digit),
  .res_last_i   (res_o.last)
);
